### rtl/rpfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfp_pkg
// Shared types and constants of the radar presence frame parser: protocol
// byte positions, marker values, reset values of the registers and the
// structures that pass between the parser and the result emitter.
// ----------------------------------------------------------------------------
package rpfp_pkg;

  // Default store size in bytes and the fixed number of range gates.
  localparam int FRAME_BYTES_DEF = 64;
  localparam int GATE_COUNT      = 9;

  // Frame layout.
  localparam int FRAME_OVERHEAD  = 10;
  localparam int LEN_KNOWN_AT    = 6;
  localparam int MIN_DATA_LEN    = 13;
  localparam int MIN_ENG_LEN     = 39;
  localparam int POS_LEN_LO      = 4;
  localparam int POS_LEN_HI      = 5;
  localparam int POS_TYPE        = 6;
  localparam int POS_HEAD_MARK   = 7;
  localparam int POS_STATE       = 8;
  localparam int POS_MDIST       = 9;
  localparam int POS_MEN         = 11;
  localparam int POS_SDIST       = 12;
  localparam int POS_SEN         = 14;
  localparam int POS_DDIST       = 15;
  localparam int GATE_MOVE_AT    = 20;
  localparam int GATE_STILL_AT   = GATE_MOVE_AT + GATE_COUNT;
  // Bytes at fixed positions that the decoder ever reads.
  localparam int KEEP_BYTES      = GATE_STILL_AT + GATE_COUNT;
  // Trailing bytes seen before the last byte of a frame.
  localparam int HIST_BYTES      = 5;

  localparam logic [7:0] HEAD_MARK  = 8'hAA;
  localparam logic [7:0] TAIL_MARK  = 8'h55;
  localparam logic [7:0] CHECK_MARK = 8'h00;

  // Register reset values.
  localparam logic [31:0] DATA_HDR_RST = 32'hF1F2F3F4;
  localparam logic [31:0] CMD_HDR_RST  = 32'hFAFBFCFD;
  localparam logic [31:0] DATA_FTR_RST = 32'hF5F6F7F8;
  localparam logic [7:0]  ENG_TYPE_RST = 8'h01;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DATA_HEADER = 3'd0,
    REG_CMD_HEADER  = 3'd1,
    REG_DATA_FOOTER = 3'd2,
    REG_ENG_TYPE    = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] data_header;
    logic [31:0] cmd_header;
    logic [31:0] data_footer;
    logic [7:0]  eng_type;
  } cfg_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_GATE   = 2'd1,
    KIND_ACK    = 2'd2
  } item_kind_e;

  // What a checked frame gives.
  typedef enum logic [1:0] {
    EVT_REPORT       = 2'd0,
    EVT_REPORT_GATES = 2'd1,
    EVT_ACK          = 2'd2
  } frame_evt_e;

  typedef struct packed {
    logic       valid;
    frame_evt_e kind;
  } frame_evt_t;

  typedef logic [KEEP_BYTES-1:0][7:0] kept_bytes_t;

  typedef struct packed {
    item_kind_e  item_kind;
    logic        last_of_frame;
    logic        presence;
    logic        moving_seen;
    logic        still_seen;
    logic [15:0] moving_distance_cm;
    logic [7:0]  move_energy;
    logic [15:0] still_distance_cm;
    logic [7:0]  still_energy;
    logic [15:0] detect_distance_cm;
    logic [7:0]  index_or_command;
    logic [7:0]  ack_status;
  } result_t;

  // Result tdata: every field but item_kind and last_of_frame, padded to bytes.
  localparam int OUT_FIELDS_W = 83;
  localparam int OUT_TDATA_W  = 88;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

endpackage : rpfp_pkg
`default_nettype wire

### rtl/rpfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfp_parser
// Header hunt, frame byte capture, length check and frame validation. Bytes
// at the positions that the decoder reads are kept in registers; the last
// bytes before the end of a frame sit in a short history line so that the
// footer and trailing markers are checked as the final byte arrives.
// ----------------------------------------------------------------------------
module rpfp_parser #(
  parameter int FRAME_BYTES = rpfp_pkg::FRAME_BYTES_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire rpfp_pkg::cfg_t  cfg,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,
  input  wire                  evt_pop,
  output rpfp_pkg::frame_evt_t evt,
  output rpfp_pkg::kept_bytes_t kept
);
  import rpfp_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           inside_r, inside_nxt;
  logic                           is_data_r, is_data_nxt;
  frame_evt_t                     evt_r, evt_nxt;
  kept_bytes_t                    kept_r;
  logic [HIST_BYTES-1:0][7:0]     hist_r;

  logic                           acc;
  logic [1:0]                     hpos;
  logic                           hdr_hit;
  logic                           full;
  logic [CNT_W-1:0]               count_p1;
  logic [15:0]                    len_word;
  logic [16:0]                    total;
  logic                           too_long;
  logic                           done;
  logic                           wr_en;
  logic                           data_ok;
  logic                           eng_frame;
  logic                           ack_ok;
  logic                           emit;
  frame_evt_e                     emit_kind;

  // Input side is free unless a checked frame still waits for its results.
  assign in_tready = !evt_r.valid || evt_pop;
  assign acc       = in_tvalid && in_tready;

  // Header hunt: the position may match either header byte.
  assign hpos    = count_r[1:0];
  assign hdr_hit = (in_tdata == cfg.data_header[{hpos, 3'b000} +: 8]) ||
                   (in_tdata == cfg.cmd_header[{hpos, 3'b000} +: 8]);

  assign full     = count_r >= CNT_W'(FRAME_BYTES);
  assign count_p1 = count_r + CNT_W'(1);

  // Length field; its high byte may be the byte arriving now.
  assign len_word = {(count_r == CNT_W'(POS_LEN_HI)) ? in_tdata : kept_r[POS_LEN_HI],
                     kept_r[POS_LEN_LO]};
  assign total    = 17'(len_word) + 17'(FRAME_OVERHEAD);
  assign too_long = total > 17'(FRAME_BYTES);
  assign done     = 17'(count_p1) >= total;

  assign wr_en = acc && (inside_r ? !full : hdr_hit);

  // Frame checks, taken with the final byte in hand.
  assign data_ok = (count_p1 >= CNT_W'(MIN_DATA_LEN)) &&
                   ({kept_r[3], kept_r[2], kept_r[1], kept_r[0]} == cfg.data_header) &&
                   ({in_tdata, hist_r[0], hist_r[1], hist_r[2]} == cfg.data_footer) &&
                   (kept_r[POS_HEAD_MARK] == HEAD_MARK) &&
                   (hist_r[4] == TAIL_MARK) && (hist_r[3] == CHECK_MARK);
  assign eng_frame = (kept_r[POS_TYPE] == cfg.eng_type) &&
                     (count_p1 >= CNT_W'(MIN_ENG_LEN));
  assign ack_ok    = {kept_r[3], kept_r[2], kept_r[1], kept_r[0]} == cfg.cmd_header;

  // Next state of the hunt and capture.
  always_comb begin
    count_nxt   = count_r;
    inside_nxt  = inside_r;
    is_data_nxt = is_data_r;
    emit        = 1'b0;
    emit_kind   = EVT_REPORT;
    if (acc) begin
      if (!inside_r) begin
        if (hdr_hit) begin
          count_nxt = count_p1;
          if (hpos == 2'd3) begin
            inside_nxt  = 1'b1;
            is_data_nxt = kept_r[0] == cfg.data_header[7:0];
          end
        end else begin
          count_nxt = '0;
        end
      end else if (full) begin
        count_nxt  = '0;
        inside_nxt = 1'b0;
      end else begin
        count_nxt = count_p1;
        if (count_p1 >= CNT_W'(LEN_KNOWN_AT)) begin
          if (too_long) begin
            count_nxt  = '0;
            inside_nxt = 1'b0;
          end else if (done) begin
            count_nxt  = '0;
            inside_nxt = 1'b0;
            if (is_data_r) begin
              emit      = data_ok;
              emit_kind = eng_frame ? EVT_REPORT_GATES : EVT_REPORT;
            end else begin
              emit      = ack_ok;
              emit_kind = EVT_ACK;
            end
          end
        end
      end
    end
  end

  // Frame event register.
  always_comb begin
    evt_nxt       = evt_r;
    evt_nxt.valid = evt_r.valid && !evt_pop;
    if (emit) begin
      evt_nxt.valid = 1'b1;
      evt_nxt.kind  = emit_kind;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      inside_r  <= 1'b0;
      is_data_r <= 1'b0;
      evt_r     <= '{valid: 1'b0, kind: EVT_REPORT};
    end else begin
      count_r   <= count_nxt;
      inside_r  <= inside_nxt;
      is_data_r <= is_data_nxt;
      evt_r     <= evt_nxt;
    end
  end

  // Kept frame bytes, each written only at its own position.
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEEP_BYTES; i++) begin
      if (wr_en && (count_r == CNT_W'(i))) begin
        kept_r[i] <= in_tdata;
      end
    end
    if (acc) begin
      hist_r <= {hist_r[HIST_BYTES-2:0], in_tdata};
    end
  end

  assign evt  = evt_r;
  assign kept = kept_r;

  // The hunt never counts past the header; a frame always has its header.
  a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
    !inside_r |-> (count_r < CNT_W'(4)))
    else $error("hunt count beyond header");

  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    inside_r |-> (count_r >= CNT_W'(4)))
    else $error("frame entered without a full header");

  // A waiting event is kept until the emitter takes it.
  a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_r.valid && !evt_pop) |=> (evt_r.valid && $stable(evt_r.kind)))
    else $error("frame event lost");

  // No byte is taken while an event waits and is not being released.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_r.valid && !evt_pop) |-> !acc)
    else $error("byte taken while frame results are pending");

endmodule : rpfp_parser
`default_nettype wire

### rtl/rpfp_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfp_emitter
// Turns one checked frame into its result items: a target report, then the
// gate energies of an engineering frame, or one acknowledgement item. A step
// counter walks the gates; every item lands in the output register.
// ----------------------------------------------------------------------------
module rpfp_emitter (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire rpfp_pkg::frame_evt_t  evt,
  input  wire rpfp_pkg::kept_bytes_t kept,
  output logic                  evt_pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output rpfp_pkg::result_t     out_item
);
  import rpfp_pkg::*;

  localparam int STEP_W = $clog2(GATE_COUNT + 1);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [STEP_W-1:0] gate_idx;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;
  result_t           item;
  logic              advance;
  logic [7:0]        gate_men;
  logic [7:0]        gate_sen;

  assign advance  = evt.valid && (!out_valid_r || out_tready);
  assign gate_idx = step_r - STEP_W'(1);

  // Gate energy select.
  always_comb begin
    gate_men = '0;
    gate_sen = '0;
    for (int g = 0; g < GATE_COUNT; g++) begin
      if (gate_idx == STEP_W'(g)) begin
        gate_men = kept[GATE_MOVE_AT + g];
        gate_sen = kept[GATE_STILL_AT + g];
      end
    end
  end

  // Build the current item; fields outside its kind stay zero.
  always_comb begin
    item = '0;
    if (evt.kind == EVT_ACK) begin
      item.item_kind        = KIND_ACK;
      item.last_of_frame    = 1'b1;
      item.index_or_command = kept[POS_TYPE];
      item.ack_status       = kept[POS_STATE];
    end else if (step_r == '0) begin
      item.item_kind          = KIND_REPORT;
      item.last_of_frame      = evt.kind == EVT_REPORT;
      item.presence           = kept[POS_STATE] != 8'h00;
      item.moving_seen        = kept[POS_STATE][0];
      item.still_seen         = kept[POS_STATE][1];
      item.moving_distance_cm = {kept[POS_MDIST + 1], kept[POS_MDIST]};
      item.move_energy        = kept[POS_MEN];
      item.still_distance_cm  = {kept[POS_SDIST + 1], kept[POS_SDIST]};
      item.still_energy       = kept[POS_SEN];
      item.detect_distance_cm = {kept[POS_DDIST + 1], kept[POS_DDIST]};
    end else begin
      item.item_kind        = KIND_GATE;
      item.last_of_frame    = step_r == STEP_W'(GATE_COUNT);
      item.move_energy      = gate_men;
      item.still_energy     = gate_sen;
      item.index_or_command = 8'(gate_idx);
    end
  end

  assign evt_pop = advance && item.last_of_frame;

  // Step counter and output register control.
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (advance) begin
      out_valid_nxt = 1'b1;
      step_nxt      = evt_pop ? '0 : step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= item;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_item   = out_r;

  // Gate steps only happen inside an engineering frame.
  a_step_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0) |-> (evt.valid && (evt.kind == EVT_REPORT_GATES)))
    else $error("gate step outside an engineering frame");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(GATE_COUNT))
    else $error("gate step out of range");

  // Releasing a frame restarts the step counter.
  a_pop_reset: assert property (@(posedge clk) disable iff (!rst_n)
    evt_pop |=> (step_r == '0))
    else $error("step counter not cleared after frame");

endmodule : rpfp_emitter
`default_nettype wire

### rtl/radar_presence_frame_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radar_presence_frame_parser_core
// Serial frame parser for a radar presence sensor: hunts the frame header,
// captures and checks the frame, and gives target reports, gate energies
// and command acknowledgements.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      tdata[7:0] rx_byte
//  out_     master     tdata: result fields; tuser: item_kind; tlast: last_of_frame
//  cfg_     slave      cfg_index register number, cfg_data 32-bit value
//
//  One byte is taken each cycle while no checked frame holds the input. A
//  byte that ends a valid frame sets the frame event register; its first
//  item then lands in the output register. An engineering frame holds the
//  input while the gate step counter walks its gate items. Output stalls
//  hold the input only while a checked frame still has items to give.
//  rst_n is synchronous and restores the default header, footer and type codes.
// ----------------------------------------------------------------------------
module radar_presence_frame_parser_core #(
  parameter int FRAME_BYTES = rpfp_pkg::FRAME_BYTES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // Received bytes
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [7:0]                         in_tdata,   // [7:0] rx_byte
  // Result items
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [0] presence, [1] moving_seen, [2] still_seen, [18:3] moving_distance_cm,
  // [26:19] move_energy, [42:27] still_distance_cm, [50:43] still_energy,
  // [66:51] detect_distance_cm, [74:67] index_or_command, [82:75] ack_status
  output logic [rpfp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [1:0]                         out_tuser,  // [1:0] item_kind
  output logic                               out_tlast,
  // Register writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [rpfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [31:0]                        cfg_data
);
  import rpfp_pkg::*;

  cfg_t        cfg_r;
  frame_evt_t  evt;
  kept_bytes_t kept;
  logic        evt_pop;
  result_t     res;
  logic        cfg_we;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{data_header: DATA_HDR_RST, cmd_header: CMD_HDR_RST,
                 data_footer: DATA_FTR_RST, eng_type: ENG_TYPE_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DATA_HEADER: cfg_r.data_header <= cfg_data;
        REG_CMD_HEADER:  cfg_r.cmd_header  <= cfg_data;
        REG_DATA_FOOTER: cfg_r.data_footer <= cfg_data;
        REG_ENG_TYPE:    cfg_r.eng_type    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rpfp_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .evt_pop   (evt_pop),
    .evt       (evt),
    .kept      (kept)
  );

  rpfp_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .kept       (kept),
    .evt_pop    (evt_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (res)
  );

  // Result packing, first field in the low bits.
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res.ack_status, res.index_or_command,
                      res.detect_distance_cm, res.still_energy, res.still_distance_cm,
                      res.move_energy, res.moving_distance_cm, res.still_seen,
                      res.moving_seen, res.presence};
  assign out_tuser = res.item_kind;
  assign out_tlast = res.last_of_frame;

endmodule : radar_presence_frame_parser_core
`default_nettype wire
